// ===== sv/gpg_pkg.sv =====
package gpg_pkg;

  // Fraction bits of the base-2 logarithm, one bit per squaring step.
  localparam int unsigned LOG_BITS = 58;

  // Digit steps of the 64-bit integer square root (two radicand bits each).
  localparam int unsigned ROOT_STEPS = 32;

  // Quotient bits of the coordinate divide.
  localparam int unsigned DIV_STEPS = 32;

  // Cap on the two-bit normalizing shifts ahead of the second square root.
  localparam int unsigned NORM_MAX = 16;

  // Base of the final rounding shift before the fraction bits are taken off.
  localparam int unsigned SHIFT_BASE = 59;

  // ln 2 in Q64.
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

  typedef logic [63:0] word_t;

endpackage

// ===== sv/gpg_isqrt_pipe.sv =====
module gpg_isqrt_pipe #(
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  gpg_pkg::word_t        in_x,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [31:0]           out_root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int N = gpg_pkg::ROOT_STEPS;

  logic                vld    [N+1];
  gpg_pkg::word_t      x_q    [N+1];
  gpg_pkg::word_t      r_q    [N+1];
  logic [SIDE_W-1:0]   side_q [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      x_q[0]    <= in_x;
      r_q[0]    <= '0;
      side_q[0] <= in_side;
    end
  end

  // One root digit per stage: the trial bit walks down two places each step.
  for (genvar g = 0; g < N; g++) begin : g_step
    localparam gpg_pkg::word_t BIT = 64'd1 << (62 - 2 * g);
    gpg_pkg::word_t trial;
    logic           ge;

    assign trial = r_q[g] + BIT;
    assign ge    = (x_q[g] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        x_q[g+1]    <= ge ? (x_q[g] - trial) : x_q[g];
        r_q[g+1]    <= ge ? ((r_q[g] >> 1) + BIT) : (r_q[g] >> 1);
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = r_q[N][31:0];
  assign out_side  = side_q[N];

endmodule

// ===== sv/gpg_log2_pipe.sv =====
module gpg_log2_pipe #(
  parameter int SIDE_W = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  gpg_pkg::word_t                in_m,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [gpg_pkg::LOG_BITS-1:0]  out_frac,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int N = gpg_pkg::LOG_BITS;

  // B stages hold the mantissa between squarings, A stages the partial products.
  logic               vb   [N+1];
  gpg_pkg::word_t     m_q  [N+1];
  logic [N-1:0]       fb_q [N+1];
  logic [SIDE_W-1:0]  sb_q [N+1];

  logic               va   [N];
  logic [63:0]        p00  [N];
  logic [63:0]        p01  [N];
  logic [63:0]        p11  [N];
  logic [N-1:0]       fa_q [N];
  logic [SIDE_W-1:0]  sa_q [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb[0] <= 1'b0;
    end else if (en) begin
      vb[0] <= in_valid;
    end
    if (en) begin
      m_q[0]  <= in_m;
      fb_q[0] <= '0;
      sb_q[0] <= in_side;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_sq
    logic [31:0]  lo_half;
    logic [31:0]  hi_half;
    logic [127:0] sq;
    logic [63:0]  sq_q62;

    assign lo_half = m_q[g][31:0];
    assign hi_half = m_q[g][63:32];

    // The cross term appears twice, so it enters one place further up.
    assign sq = {p11[g], 64'd0} + {31'd0, p01[g], 33'd0} + {64'd0, p00[g]};
    assign sq_q62 = sq[125:62];

    always_ff @(posedge clk) begin
      if (rst) begin
        va[g]   <= 1'b0;
        vb[g+1] <= 1'b0;
      end else if (en) begin
        va[g]   <= vb[g];
        vb[g+1] <= va[g];
      end
      if (en) begin
        p00[g]  <= lo_half * lo_half;
        p01[g]  <= lo_half * hi_half;
        p11[g]  <= hi_half * hi_half;
        fa_q[g] <= fb_q[g];
        sa_q[g] <= sb_q[g];
        // A square of two or more yields a one bit and is halved.
        m_q[g+1]  <= sq_q62[63] ? (sq_q62 >> 1) : sq_q62;
        fb_q[g+1] <= {fa_q[g][N-2:0], sq_q62[63]};
        sb_q[g+1] <= sa_q[g];
      end
    end
  end

  assign out_valid = vb[N];
  assign out_frac  = fb_q[N];
  assign out_side  = sb_q[N];

endmodule

// ===== sv/gaussian_polar_generator.sv =====
// Pipeline: 232 register stages; the second result beat of a pair is presented in the cycle
// after its first beat is taken.
// Intake: one input beat per cycle while the pipeline is not stalled; each pair puts two
// result beats on the single output port, so a steady stream of accepted pairs stalls the input.
// Reset (rst, synchronous, active high) clears all valid bits, the output pair and
// output_mode; data registers are not reset and no clearing pass is needed.
module gaussian_polar_generator #(
  parameter int FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] uniform_first, [63:32] uniform_second
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sample_value
  output logic        m_axis_tlast,   // last_of_pair
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  // Side band widths for the two square roots and the logarithm pipeline.
  localparam int SIDE_D_W = 136;
  localparam int SIDE_L_W = 72;
  localparam int SIDE_W_W = 71;
  localparam int NDIV     = gpg_pkg::DIV_STEPS;
  localparam int LB       = gpg_pkg::LOG_BITS;

  // Rounding shift without the j and mode terms: 59 - FRAC_BITS.
  localparam int SH_BASE = gpg_pkg::SHIFT_BASE - FRAC_BITS;
  localparam logic signed [34:0] HALF   = 35'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
  localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

  // The whole pipeline advances together. It holds only while its last stage carries a
  // pair and the output pair register cannot take it.
  logic en;
  logic pair_free;
  logic pair_valid;
  logic pair_sel;
  logic [31:0] pair_first;
  logic [31:0] pair_second;

  logic output_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode <= 1'b0;
    end else if (cfg_valid) begin
      output_mode <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: each raw word r maps to V = 2r + 1 - 2^32; |V| is r's low bits, inverted when
  // r lies in the lower half, with a one appended; V is negative in the lower half.
  // ---------------------------------------------------------------------------------------
  logic        s1_valid;
  logic [31:0] s1_mag1, s1_mag2;
  logic        s1_neg1, s1_neg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_axis_tvalid;
    end
    if (en) begin
      s1_mag1 <= {s_axis_tdata[31] ? s_axis_tdata[30:0] : ~s_axis_tdata[30:0], 1'b1};
      s1_mag2 <= {s_axis_tdata[63] ? s_axis_tdata[62:32] : ~s_axis_tdata[62:32], 1'b1};
      s1_neg1 <= ~s_axis_tdata[31];
      s1_neg2 <= ~s_axis_tdata[63];
    end
  end

  // Stage 2: squares of the two coordinates, exact with 64 fraction bits.
  logic        s2_valid;
  logic [63:0] s2_sq1, s2_sq2;
  logic [31:0] s2_mag1, s2_mag2;
  logic        s2_neg1, s2_neg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_sq1  <= s1_mag1 * s1_mag1;
      s2_sq2  <= s1_mag2 * s1_mag2;
      s2_mag1 <= s1_mag1;
      s2_mag2 <= s1_mag2;
      s2_neg1 <= s1_neg1;
      s2_neg2 <= s1_neg2;
    end
  end

  // Stage 3: d = v1^2 + v2^2. A carry out means d >= 1 and the pair is dropped here, as is
  // a zero sum. A dropped pair simply becomes a bubble.
  logic [64:0] d_sum;
  logic        s3_valid;
  logic [63:0] s3_d;
  logic [31:0] s3_mag1, s3_mag2;
  logic        s3_neg1, s3_neg2;

  assign d_sum = {1'b0, s2_sq1} + {1'b0, s2_sq2};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid && !d_sum[64] && (d_sum[63:0] != '0);
    end
    if (en) begin
      s3_d    <= d_sum[63:0];
      s3_mag1 <= s2_mag1;
      s3_mag2 <= s2_mag2;
      s3_neg1 <= s2_neg1;
      s3_neg2 <= s2_neg2;
    end
  end

  // Stages 4 to 6: leading-zero count of d by a three-stage normalizing shifter, two shift
  // decisions per stage.
  logic [63:0] n4_d;
  logic [1:0]  n4_z;
  logic        s4_valid;
  logic [63:0] s4_d;
  logic [1:0]  s4_z;
  logic [31:0] s4_mag1, s4_mag2;
  logic        s4_neg1, s4_neg2;

  always_comb begin
    n4_d = s3_d;
    n4_z = '0;
    if (n4_d[63:32] == '0) begin
      n4_d    = n4_d << 32;
      n4_z[1] = 1'b1;
    end
    if (n4_d[63:48] == '0) begin
      n4_d    = n4_d << 16;
      n4_z[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
    if (en) begin
      s4_d    <= n4_d;
      s4_z    <= n4_z;
      s4_mag1 <= s3_mag1;
      s4_mag2 <= s3_mag2;
      s4_neg1 <= s3_neg1;
      s4_neg2 <= s3_neg2;
    end
  end

  logic [63:0] n5_d;
  logic [1:0]  n5_z;
  logic        s5_valid;
  logic [63:0] s5_d;
  logic [3:0]  s5_z;
  logic [31:0] s5_mag1, s5_mag2;
  logic        s5_neg1, s5_neg2;

  always_comb begin
    n5_d = s4_d;
    n5_z = '0;
    if (n5_d[63:56] == '0) begin
      n5_d    = n5_d << 8;
      n5_z[1] = 1'b1;
    end
    if (n5_d[63:60] == '0) begin
      n5_d    = n5_d << 4;
      n5_z[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
    if (en) begin
      s5_d    <= n5_d;
      s5_z    <= {s4_z, n5_z};
      s5_mag1 <= s4_mag1;
      s5_mag2 <= s4_mag2;
      s5_neg1 <= s4_neg1;
      s5_neg2 <= s4_neg2;
    end
  end

  logic [63:0] n6_d;
  logic [1:0]  n6_z;
  logic        s6_valid;
  logic [63:0] s6_dn;
  logic [5:0]  s6_z;
  logic [31:0] s6_mag1, s6_mag2;
  logic        s6_neg1, s6_neg2;

  always_comb begin
    n6_d = s5_d;
    n6_z = '0;
    if (n6_d[63:62] == '0) begin
      n6_d    = n6_d << 2;
      n6_z[1] = 1'b1;
    end
    if (n6_d[63] == 1'b0) begin
      n6_d    = n6_d << 1;
      n6_z[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
    if (en) begin
      s6_dn   <= n6_d;
      s6_z    <= {s5_z, n6_z};
      s6_mag1 <= s5_mag1;
      s6_mag2 <= s5_mag2;
      s6_neg1 <= s5_neg1;
      s6_neg2 <= s5_neg2;
    end
  end

  // Stage 7: mantissa m in Q62, the radicand d shifted by an even amount 2k = z or z - 1,
  // and the coordinates scaled by 2^k. Those never exceed the root of the radicand, so
  // they stay within 32 bits.
  logic [4:0]  k_shift;
  logic        s7_valid;
  logic [63:0] s7_m, s7_x0;
  logic [31:0] s7_a1, s7_a2;
  logic [5:0]  s7_z;
  logic        s7_neg1, s7_neg2;

  assign k_shift = s6_z[5:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid;
    end
    if (en) begin
      s7_m    <= s6_dn >> 1;
      s7_x0   <= s6_z[0] ? (s6_dn >> 1) : s6_dn;
      s7_a1   <= s6_mag1 << k_shift;
      s7_a2   <= s6_mag2 << k_shift;
      s7_z    <= s6_z;
      s7_neg1 <= s6_neg1;
      s7_neg2 <= s6_neg2;
    end
  end

  // Root of the shifted d: s, between 2^31 and 2^32 - 1.
  logic                rd_valid;
  logic [31:0]         rd_root;
  logic [SIDE_D_W-1:0] rd_side;

  gpg_isqrt_pipe #(
    .SIDE_W (SIDE_D_W)
  ) u_root_d (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s7_valid),
    .in_x      (s7_x0),
    .in_side   ({s7_neg1, s7_neg2, s7_a1, s7_a2, s7_m, s7_z}),
    .out_valid (rd_valid),
    .out_root  (rd_root),
    .out_side  (rd_side)
  );

  // Stage 8: dividends (a << 31) + s / 2 for both coordinates. The quotient fits in 32 bits,
  // so the upper word already is the first partial remainder.
  logic [63:0] num1, num2;

  assign num1 = {1'b0, rd_side[133:102], 31'd0} + {33'd0, rd_root[31:1]};
  assign num2 = {1'b0, rd_side[101:70], 31'd0} + {33'd0, rd_root[31:1]};

  logic        dv_valid [NDIV+1];
  logic [31:0] dv_r1    [NDIV+1];
  logic [31:0] dv_q1    [NDIV+1];
  logic [31:0] dv_r2    [NDIV+1];
  logic [31:0] dv_q2    [NDIV+1];
  logic [31:0] dv_s     [NDIV+1];
  logic [63:0] dv_m     [NDIV+1];
  logic [5:0]  dv_z     [NDIV+1];
  logic [1:0]  dv_neg   [NDIV+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= rd_valid;
    end
    if (en) begin
      dv_r1[0]  <= num1[63:32];
      dv_q1[0]  <= num1[31:0];
      dv_r2[0]  <= num2[63:32];
      dv_q2[0]  <= num2[31:0];
      dv_s[0]   <= rd_root;
      dv_m[0]   <= rd_side[69:6];
      dv_z[0]   <= rd_side[5:0];
      dv_neg[0] <= rd_side[135:134];
    end
  end

  // Restoring division, one quotient bit per stage for each coordinate. The low register
  // shifts the remaining dividend bits out at the top and the quotient bits in below.
  for (genvar g = 0; g < NDIV; g++) begin : g_div
    logic [32:0] t1, t2;
    logic        ge1, ge2;
    logic [32:0] d1, d2;

    assign t1  = {dv_r1[g], dv_q1[g][31]};
    assign t2  = {dv_r2[g], dv_q2[g][31]};
    assign ge1 = (t1 >= {1'b0, dv_s[g]});
    assign ge2 = (t2 >= {1'b0, dv_s[g]});
    assign d1  = t1 - {1'b0, dv_s[g]};
    assign d2  = t2 - {1'b0, dv_s[g]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[g+1] <= 1'b0;
      end else if (en) begin
        dv_valid[g+1] <= dv_valid[g];
      end
      if (en) begin
        dv_r1[g+1]  <= ge1 ? d1[31:0] : t1[31:0];
        dv_q1[g+1]  <= {dv_q1[g][30:0], ge1};
        dv_r2[g+1]  <= ge2 ? d2[31:0] : t2[31:0];
        dv_q2[g+1]  <= {dv_q2[g][30:0], ge2};
        dv_s[g+1]   <= dv_s[g];
        dv_m[g+1]   <= dv_m[g];
        dv_z[g+1]   <= dv_z[g];
        dv_neg[g+1] <= dv_neg[g];
      end
    end
  end

  // Base-2 logarithm of the mantissa by repeated squaring; v / sqrt(d) in Q31 rides along.
  logic                lg_valid;
  logic [LB-1:0]       lg_frac;
  logic [SIDE_L_W-1:0] lg_side;

  gpg_log2_pipe #(
    .SIDE_W (SIDE_L_W)
  ) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv_valid[NDIV]),
    .in_m      (dv_m[NDIV]),
    .in_side   ({dv_q1[NDIV], dv_q2[NDIV], dv_neg[NDIV], dv_z[NDIV]}),
    .out_valid (lg_valid),
    .out_frac  (lg_frac),
    .out_side  (lg_side)
  );

  // Stage 9: -log2 d = (z + 1) - log2 m in Q58.
  logic [5:0]  z_plus;
  logic        s9_valid;
  logic [63:0] s9_l2;
  logic [31:0] s9_c1, s9_c2;
  logic [1:0]  s9_neg;

  assign z_plus = lg_side[5:0] + 6'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else if (en) begin
      s9_valid <= lg_valid;
    end
    if (en) begin
      s9_l2  <= (64'(z_plus) << LB) - 64'(lg_frac);
      s9_c1  <= lg_side[71:40];
      s9_c2  <= lg_side[39:8];
      s9_neg <= lg_side[7:6];
    end
  end

  // Stage 10: partial products of the log times ln 2, four 32 by 32 multipliers.
  logic        s10_valid;
  logic [63:0] s10_pp00, s10_pp01, s10_pp10, s10_pp11;
  logic [31:0] s10_c1, s10_c2;
  logic [1:0]  s10_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else if (en) begin
      s10_valid <= s9_valid;
    end
    if (en) begin
      s10_pp00 <= s9_l2[31:0]  * gpg_pkg::LN2_Q64[31:0];
      s10_pp01 <= s9_l2[31:0]  * gpg_pkg::LN2_Q64[63:32];
      s10_pp10 <= s9_l2[63:32] * gpg_pkg::LN2_Q64[31:0];
      s10_pp11 <= s9_l2[63:32] * gpg_pkg::LN2_Q64[63:32];
      s10_c1   <= s9_c1;
      s10_c2   <= s9_c2;
      s10_neg  <= s9_neg;
    end
  end

  // Stage 11: upper word of the product is -ln d in Q58; halving it gives -2 ln d in Q56.
  logic [127:0] ln_full;
  logic         s11_valid;
  logic [63:0]  s11_w;
  logic [31:0]  s11_c1, s11_c2;
  logic [1:0]   s11_neg;

  assign ln_full = {s10_pp11, 64'd0} + {32'd0, s10_pp01, 32'd0}
                 + {32'd0, s10_pp10, 32'd0} + {64'd0, s10_pp00};

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_valid <= 1'b0;
    end else if (en) begin
      s11_valid <= s10_valid;
    end
    if (en) begin
      s11_w   <= {1'b0, ln_full[127:65]};
      s11_c1  <= s10_c1;
      s11_c2  <= s10_c2;
      s11_neg <= s10_neg;
    end
  end

  // Stages 12 and 13: shift w up by pairs of bits until bit 62 or 63 is set, at most
  // sixteen pairs. j counts the pairs. A 32-bit leading gap uses up the whole budget.
  logic [63:0] wn_w;
  logic [4:0]  wn_j;
  logic        wn_done;
  logic        s12_valid;
  logic [63:0] s12_w;
  logic [4:0]  s12_j;
  logic        s12_done;
  logic [31:0] s12_c1, s12_c2;
  logic [1:0]  s12_neg;

  always_comb begin
    wn_w    = s11_w;
    wn_j    = '0;
    wn_done = 1'b0;
    if (s11_w[63:32] == '0) begin
      wn_w    = s11_w << 32;
      wn_j    = 5'(gpg_pkg::NORM_MAX);
      wn_done = 1'b1;
    end else if (s11_w[63:48] == '0) begin
      wn_w = s11_w << 16;
      wn_j = 5'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_valid <= 1'b0;
    end else if (en) begin
      s12_valid <= s11_valid;
    end
    if (en) begin
      s12_w    <= wn_w;
      s12_j    <= wn_j;
      s12_done <= wn_done;
      s12_c1   <= s11_c1;
      s12_c2   <= s11_c2;
      s12_neg  <= s11_neg;
    end
  end

  logic [63:0] wm_w;
  logic [4:0]  wm_j;
  logic        s13_valid;
  logic [63:0] s13_w;
  logic [4:0]  s13_j;
  logic [31:0] s13_c1, s13_c2;
  logic [1:0]  s13_neg;

  always_comb begin
    wm_w = s12_w;
    wm_j = s12_j;
    if (!s12_done) begin
      if (wm_w[63:56] == '0) begin
        wm_w = wm_w << 8;
        wm_j = wm_j + 5'd4;
      end
      if (wm_w[63:60] == '0) begin
        wm_w = wm_w << 4;
        wm_j = wm_j + 5'd2;
      end
      if (wm_w[63:62] == '0) begin
        wm_w = wm_w << 2;
        wm_j = wm_j + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s13_valid <= 1'b0;
    end else if (en) begin
      s13_valid <= s12_valid;
    end
    if (en) begin
      s13_w   <= wm_w;
      s13_j   <= wm_j;
      s13_c1  <= s12_c1;
      s13_c2  <= s12_c2;
      s13_neg <= s12_neg;
    end
  end

  // sqrt(-2 ln d) with 28 + j fraction bits.
  logic                rw_valid;
  logic [31:0]         rw_root;
  logic [SIDE_W_W-1:0] rw_side;

  gpg_isqrt_pipe #(
    .SIDE_W (SIDE_W_W)
  ) u_root_w (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s13_valid),
    .in_x      (s13_w),
    .in_side   ({s13_c1, s13_c2, s13_neg, s13_j}),
    .out_valid (rw_valid),
    .out_root  (rw_root),
    .out_side  (rw_side)
  );

  // Stage 14: magnitude of each sample before rounding.
  logic        s14_valid;
  logic [63:0] s14_p1, s14_p2;
  logic [1:0]  s14_neg;
  logic [4:0]  s14_j;

  always_ff @(posedge clk) begin
    if (rst) begin
      s14_valid <= 1'b0;
    end else if (en) begin
      s14_valid <= rw_valid;
    end
    if (en) begin
      s14_p1  <= rw_side[70:39] * rw_root;
      s14_p2  <= rw_side[38:7] * rw_root;
      s14_neg <= rw_side[6:5];
      s14_j   <= rw_side[4:0];
    end
  end

  // Stage 15: add half an LSB of the target format. Shifted mode keeps two fewer bits.
  logic [5:0]  rnd_sh;
  logic [63:0] rnd_bit;
  logic        s15_valid;
  logic [63:0] s15_p1, s15_p2;
  logic [5:0]  s15_sh;
  logic [1:0]  s15_neg;

  assign rnd_sh  = 6'(SH_BASE) + {1'b0, s14_j} + (output_mode ? 6'd2 : 6'd0);
  assign rnd_bit = 64'd1 << (rnd_sh - 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s15_valid <= 1'b0;
    end else if (en) begin
      s15_valid <= s14_valid;
    end
    if (en) begin
      s15_p1  <= s14_p1 + rnd_bit;
      s15_p2  <= s14_p2 + rnd_bit;
      s15_sh  <= rnd_sh;
      s15_neg <= s14_neg;
    end
  end

  // Stage 16: drop the fraction bits beyond the target format.
  logic [63:0] q1_full, q2_full;
  logic        s16_valid;
  logic [32:0] s16_q1, s16_q2;
  logic [1:0]  s16_neg;

  assign q1_full = s15_p1 >> s15_sh;
  assign q2_full = s15_p2 >> s15_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s16_valid <= 1'b0;
    end else if (en) begin
      s16_valid <= s15_valid;
    end
    if (en) begin
      s16_q1  <= q1_full[32:0];
      s16_q2  <= q2_full[32:0];
      s16_neg <= s15_neg;
    end
  end

  // Sign goes on after rounding, so ties round away from zero. Shifted mode then adds one
  // half, and the result saturates to the 32-bit range.
  function automatic logic [31:0] finish_sample(logic [32:0] q, logic neg, logic mode);
    logic signed [34:0] v;
    logic [31:0]        r;
    v = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    if (mode) begin
      v = v + HALF;
    end
    if (v > SAT_HI) begin
      r = 32'h7FFFFFFF;
    end else if (v < SAT_LO) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Output pair register: the sample from uniform_second goes out first, then the one from
  // uniform_first with tlast. A new pair loads while the second beat is being taken.
  assign pair_free     = !pair_valid || (pair_sel && m_axis_tready);
  assign en            = !s16_valid || pair_free;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      pair_sel   <= 1'b0;
    end else if (en && s16_valid) begin
      pair_valid <= 1'b1;
      pair_sel   <= 1'b0;
    end else if (pair_valid && m_axis_tready) begin
      if (!pair_sel) begin
        pair_sel <= 1'b1;
      end else begin
        pair_sel   <= 1'b0;
        pair_valid <= 1'b0;
      end
    end
    if (en && s16_valid) begin
      pair_first  <= finish_sample(s16_q2, s16_neg[0], output_mode);
      pair_second <= finish_sample(s16_q1, s16_neg[1], output_mode);
    end
  end

  assign m_axis_tvalid = pair_valid;
  assign m_axis_tdata  = pair_sel ? pair_second : pair_first;
  assign m_axis_tlast  = pair_sel;

`ifndef NO_ASSERTIONS
  // A first beat that is taken is always followed by the closing beat of its pair.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("first beat of a pair not followed by its last beat");

  // A pair leaving the pipeline always shows up as a fresh first beat.
  assert property (@(posedge clk) disable iff (rst)
    (en && s16_valid) |=> (m_axis_tvalid && !m_axis_tlast))
    else $error("pair loaded but first beat not presented");

  // Intake only stops while a finished pair waits behind a busy output register.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s16_valid && pair_valid && !(pair_sel && m_axis_tready)))
    else $error("input stalled without a blocked output");

  // No pair with a zero sum of squares gets past the rejection stage.
  assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_d != '0))
    else $error("zero sum of squares passed rejection");
`endif

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

  // One expected sample beat on the result channel.
  typedef struct {
    logic signed [31:0] sample;
    logic               last;
  } sample_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  logic [63:0]  pair_queue[$];     // uniform pairs waiting for the driver
  sample_beat_t sample_queue[$];   // predicted samples, oldest first
  logic         scaled_mode = 1'b0; // mirror of output_mode
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_request = 0;   // long receiver hold-off, in cycles
  int           hold_left = 0;
  bit           pair_taken = 1'b0;
  int           errors = 0;
  int           quiet_cycles = 0;

  localparam int DRAIN_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;

  gaussian_polar_generator uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Upper 64 bits of a full 64x64 product.
  function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[127:64];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Magnitude of the coordinate 2u-1 in Q32; neg is set when it is below zero.
  function automatic logic [63:0] coord_magnitude(input logic [31:0] raw, output bit neg);
    logic [63:0] t;
    t = 2 * {32'd0, raw} + 1;
    neg = (t < (64'd1 << 32));
    return neg ? (64'd1 << 32) - t : t - (64'd1 << 32);
  endfunction

  // Scales one coordinate by the shared polar factor and rounds to the output format.
  function automatic logic [31:0] scale_coord(input logic [63:0] a, input bit neg,
      input logic [63:0] root_d, input logic [63:0] root_w, input int nshift);
    logic [63:0] ratio, prod, mag;
    longint signed val;
    int sh;
    ratio = ((a << 31) + (root_d >> 1)) / root_d;
    prod = ratio * root_w;
    sh = 59 + nshift - 28 + (scaled_mode ? 2 : 0);
    mag = (prod + (64'd1 << (sh - 1))) >> sh;
    val = neg ? -$signed(mag) : $signed(mag);
    if (scaled_mode) val = val + (64'sd1 <<< 27);
    if (val > 64'sd2147483647) val = 64'sd2147483647;
    if (val < -64'sd2147483648) val = -64'sd2147483648;
    return val[31:0];
  endfunction

  // Predicts the samples of one uniform pair; a rejected pair adds nothing.
  function automatic void predict_pair(input logic [63:0] pair);
    bit neg1, neg2;
    logic [63:0] m1, m2, sq1, sq2, radius_sq, mant, frac, l2, lnat, w, root_d, root_w;
    logic [127:0] sq;
    logic [64:0] sum;
    int z, k, nshift;
    sample_beat_t beat;
    m1 = coord_magnitude(pair[31:0], neg1);
    m2 = coord_magnitude(pair[63:32], neg2);
    sq1 = m1 * m1;
    sq2 = m2 * m2;
    sum = {1'b0, sq1} + {1'b0, sq2};
    radius_sq = sum[63:0];
    if (sum[64] || radius_sq == 0) return;
    z = 0;
    while (z < 64 && radius_sq[63 - z] == 1'b0) z++;
    mant = (radius_sq << z) >> 1;
    frac = 0;
    // log2 of the mantissa by repeated squaring, one bit per step.
    for (int i = 0; i < gpg_pkg::LOG_BITS; i++) begin
      sq = {64'd0, mant} * {64'd0, mant};
      mant = sq[125:62];
      frac = frac << 1;
      if (mant[63]) begin
        frac[0] = 1'b1;
        mant = mant >> 1;
      end
    end
    l2 = (64'(z + 1) << gpg_pkg::LOG_BITS) - frac;
    lnat = mul_hi(l2, gpg_pkg::LN2_Q64);
    w = lnat >> 1;
    nshift = 0;
    while (nshift < gpg_pkg::NORM_MAX && w < (64'd1 << 62)) begin
      w = w << 2;
      nshift++;
    end
    root_w = int_sqrt(w);
    k = z >> 1;
    root_d = int_sqrt(radius_sq << (2 * k));
    beat.sample = scale_coord(m2 << k, neg2, root_d, root_w, nshift);
    beat.last = 1'b0;
    sample_queue.push_back(beat);
    beat.sample = scale_coord(m1 << k, neg1, root_d, root_w, nshift);
    beat.last = 1'b1;
    sample_queue.push_back(beat);
  endfunction

  // Input side: an accepted pair is predicted at the edge where it is taken.
  always @(posedge clk) begin
    pair_taken = s_axis_tvalid && s_axis_tready && !rst;
    if (pair_taken) predict_pair(s_axis_tdata);
  end

  // Driver: offers the next pending pair once the current beat has been taken.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || pair_taken) begin
      if (pair_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata <= pair_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: every result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    sample_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sample_queue.size() == 0) begin
        $display("%0t: unexpected sample beat %h last %b", $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = sample_queue.pop_front();
        if (m_axis_tdata !== want.sample) begin
          $display("%0t: sample mismatch, expected %h actual %h", $time, want.sample,
                   m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last flag mismatch, expected %b actual %b", $time, want.last,
                   m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles with work outstanding and no beat moving.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pair_queue.size() == 0 && sample_queue.size() == 0 && !s_axis_tvalid))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Waits for all queued pairs to go in and all predicted samples to come out,
  // then for the pipeline to flush any rejected pairs still in flight.
  task automatic drain_block();
    while (pair_queue.size() > 0 || s_axis_tvalid || sample_queue.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    scaled_mode = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Extremes of the coordinates, rejected pairs and pairs that saturate in the reset mode.
  task automatic load_directed();
    logic [31:0] corner[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0001, 32'h7FFF_FFFE, 32'hDA82_7999, 32'h257D_8666};
    pair_queue.push_back({32'h8000_0001, 32'h8000_0000});  // saturates high in the reset mode
    pair_queue.push_back({32'h7FFF_FFFE, 32'h8000_0000});  // saturates low in the reset mode
    pair_queue.push_back({32'h8000_0000, 32'h8000_0000});  // smallest radius
    pair_queue.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pair_queue.push_back({32'h0000_0000, 32'h0000_0000});  // rejected
    pair_queue.push_back({32'hFFFF_FFFF, 32'h0000_0000});  // rejected
    pair_queue.push_back({32'hDA82_7999, 32'hDA82_7999});  // radius near one
    pair_queue.push_back({32'hDA82_7999, 32'h257D_8666});
    for (int i = 0; i < 8; i++)
      pair_queue.push_back({corner[(i * 3 + 1) % 8], corner[i]});
    pair_queue.push_back({32'h8000_0000, 32'hFFFF_FFFF});
    pair_queue.push_back({32'h8000_0000, 32'h0000_0000});
    pair_queue.push_back({32'hFFFF_FFFF, 32'h8000_0000});
    pair_queue.push_back({32'h0000_0000, 32'h7FFF_FFFF});
  endtask

  task automatic load_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0)
        // Small coordinates push the radius toward zero and the samples outward.
        pair_queue.push_back({32'h8000_0000 ^ ($urandom() >> $urandom_range(31)),
                              32'h8000_0000 ^ ($urandom() >> $urandom_range(31))});
      else
        pair_queue.push_back({$urandom(), $urandom()});
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pairs in both output modes, the reset mode first.
    load_directed();
    drain_block();
    write_mode(1'b1);
    load_directed();
    drain_block();

    // Random pairs under each idling pattern, switching the mode between phases.
    // The first batch holds more accepted pairs than the pipeline has stages.
    write_mode(1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_random(360);
    @(posedge clk);
    hold_request = 600;  // the block fills up and must stall its input
    drain_block();

    write_mode(1'b1);
    send_idle_pct = 49;
    recv_stall_pct = 0;
    load_random(260);
    drain_block();

    write_mode(1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    load_random(260);
    drain_block();

    write_mode(1'b1);
    send_idle_pct = 17;
    recv_stall_pct = 17;
    load_random(140);
    drain_block();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
